[rtl/alr_pkg.sv]
// Shared widths, constants and types for the antialiased line rasterizer.
`timescale 1ns / 1ps

package alr_pkg;

  localparam int MAX_DIM   = 64;
  localparam int DIM_W     = 7;
  localparam int POS_W     = 6;
  localparam int FRAC_BITS = 8;
  localparam int ADDR_W    = 12;
  localparam int ALPHA_W   = 8;
  localparam int RGB_W     = 24;
  localparam int IN_W      = 40;
  localparam int OUT_W     = 96;

  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  typedef enum logic [8:0] {
    ST_IDLE   = 9'b000000001,
    ST_THIN   = 9'b000000010,
    ST_ENDPT  = 9'b000000100,
    ST_STEP   = 9'b000001000,
    ST_DIV    = 9'b000010000,
    ST_SHADE1 = 9'b000100000,
    ST_SHADE2 = 9'b001000000,
    ST_ADDR   = 9'b010000000,
    ST_WAIT   = 9'b100000000
  } state_t;

endpackage

[rtl/alr_frac_div.sv]
// Bit-serial restoring divider for the 8-bit fraction (rem * 256) / den.
`timescale 1ns / 1ps

module alr_frac_div (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [alr_pkg::POS_W-1:0]       rem,
  input  logic [alr_pkg::POS_W-1:0]       den,
  output logic                            done,
  output logic [alr_pkg::FRAC_BITS-1:0]   frac
);

  logic                          running;
  logic [2:0]                    cnt;
  logic [alr_pkg::POS_W-1:0]     partial;
  logic [alr_pkg::POS_W:0]       trial;
  logic                          ge;

  assign trial = {partial, 1'b0};
  assign ge    = trial >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= running && (cnt == 3'd7);
      if (start) begin
        running <= 1'b1;
        cnt     <= '0;
      end else if (running) begin
        cnt <= cnt + 3'd1;
        if (cnt == 3'd7) begin
          running <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      partial <= rem;
      frac    <= '0;
    end else if (running) begin
      partial <= ge ? alr_pkg::POS_W'(trial - {1'b0, den}) : alr_pkg::POS_W'(trial);
      frac    <= {frac[alr_pkg::FRAC_BITS-2:0], ge};
    end
  end

endmodule

[rtl/antialiased_line_raster.sv]
// Top level of the antialiased diagonal line rasterizer.
// Each request draws a corner-to-corner antialiased line over the configured
// surface and returns pixel writes two per result, the endpoints first. A
// surface one pixel wide or high is filled whole; each result is formed in
// ST_THIN, then held in ST_WAIT for the output handshake. Otherwise the
// endpoint result is formed in ST_ENDPT, and each interior step advances the
// rational position in ST_STEP, runs the bit-serial fraction divider in
// ST_DIV, then makes two alpha scalings and one address on the single shared
// multiplier in ST_SHADE1, ST_SHADE2 and ST_ADDR; ST_WAIT then holds each
// result until it is taken. No new request is taken until the last result
// leaves.
`timescale 1ns / 1ps

module antialiased_line_raster (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic                               cfg_index,
  input  logic [alr_pkg::DIM_W-1:0]          cfg_data,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // color_alpha[7:0], color_rgb[31:8], rising_slope[32], zero[39:33]
  input  logic [alr_pkg::IN_W-1:0]           s_axis_tdata,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // addr_first[11:0], value_first[43:12], second_valid[44], addr_second[56:45],
  // value_second[88:57], zero[95:89]
  output logic [alr_pkg::OUT_W-1:0]          m_axis_tdata,
  output logic                               m_axis_tlast
);

  function automatic logic [alr_pkg::DIM_W-1:0] clamp_dim(
    input logic [alr_pkg::DIM_W-1:0] v
  );
    logic [alr_pkg::DIM_W-1:0] r;
    begin
      r = v;
      if (v == '0) r = alr_pkg::DIM_W'(1);
      else if (v > alr_pkg::DIM_W'(alr_pkg::MAX_DIM)) r = alr_pkg::DIM_W'(alr_pkg::MAX_DIM);
      return r;
    end
  endfunction

  alr_pkg::state_t state;
  logic            div_start;
  logic            div_done;

  logic [alr_pkg::DIM_W-1:0]     surf_w, surf_h;
  logic [alr_pkg::DIM_W-1:0]     w, h, major, total, p;
  logic [alr_pkg::POS_W-1:0]     span, den, step, pos, rem;
  logic                          steep, dir;
  logic [alr_pkg::ALPHA_W-1:0]   alpha, alpha1;
  logic [alr_pkg::RGB_W-1:0]     rgb;
  logic [alr_pkg::FRAC_BITS-1:0] frac;
  logic                          thin;

  logic [alr_pkg::ADDR_W-1:0]    addr1, addr2;
  logic [31:0]                   val1, val2;
  logic                          ok2, out_valid, out_last;

  logic [7:0]                    mul_a;
  logic [8:0]                    mul_b;
  logic [16:0]                   prod;

  logic [alr_pkg::DIM_W-1:0]     w_in, h_in;
  logic [alr_pkg::DIM_W:0]       rem_sum;
  logic [alr_pkg::POS_W-1:0]     row, col;
  logic [alr_pkg::ADDR_W-1:0]    a1_calc;
  logic [alr_pkg::DIM_W:0]       p_next2;

  assign w_in = clamp_dim(surf_w);
  assign h_in = clamp_dim(surf_h);

  assign s_axis_tready = (state == alr_pkg::ST_IDLE);
  assign m_axis_tvalid = out_valid;
  assign m_axis_tlast  = out_last;
  assign m_axis_tdata  = {7'd0, val2, addr2, ok2, val1, addr1};

  assign div_start = (state == alr_pkg::ST_STEP);

  alr_frac_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .rem   (rem_sum >= {2'b00, den} ? alr_pkg::POS_W'(rem_sum - {2'b00, den})
                                    : alr_pkg::POS_W'(rem_sum)),
    .den   (den),
    .done  (div_done),
    .frac  (frac)
  );

  assign rem_sum = {2'b00, rem} + {2'b00, span};
  assign row     = dir ? step : alr_pkg::POS_W'(h - alr_pkg::DIM_W'(1) - {1'b0, step});
  assign col     = dir ? step : alr_pkg::POS_W'(w - alr_pkg::DIM_W'(1) - {1'b0, step});
  assign p_next2 = {1'b0, p} + 8'd2;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      alr_pkg::ST_ENDPT: begin
        mul_a = {1'b0, w};
        mul_b = dir ? {2'b00, h} : {2'b00, h - alr_pkg::DIM_W'(1)};
      end
      alr_pkg::ST_SHADE1: begin
        mul_a = alpha;
        mul_b = 9'd256 - {1'b0, frac};
      end
      alr_pkg::ST_SHADE2: begin
        mul_a = alpha;
        mul_b = {1'b0, frac};
      end
      alr_pkg::ST_ADDR: begin
        mul_a = steep ? {2'b00, row} : {2'b00, pos};
        mul_b = {2'b00, w};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod    = {9'd0, mul_a} * {8'd0, mul_b};
  assign a1_calc = alr_pkg::ADDR_W'(prod) + (steep ? {6'd0, pos} : {6'd0, col});

  always_ff @(posedge clk) begin
    if (rst) begin
      surf_w <= alr_pkg::DIM_W'(alr_pkg::MAX_DIM);
      surf_h <= alr_pkg::DIM_W'(alr_pkg::MAX_DIM);
    end else if (cfg_we) begin
      unique case (cfg_index)
        alr_pkg::REG_WIDTH:  surf_w <= cfg_data;
        alr_pkg::REG_HEIGHT: surf_h <= cfg_data;
        default:             surf_w <= surf_w;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= alr_pkg::ST_IDLE;
      out_valid <= 1'b0;
      out_last  <= 1'b0;
    end else begin
      unique case (state)
        alr_pkg::ST_IDLE: begin
          if (s_axis_tvalid) begin
            state <= (w_in == alr_pkg::DIM_W'(1) || h_in == alr_pkg::DIM_W'(1))
                     ? alr_pkg::ST_THIN : alr_pkg::ST_ENDPT;
          end
        end
        alr_pkg::ST_THIN: begin
          out_valid <= 1'b1;
          out_last  <= p_next2 >= {1'b0, total};
          state     <= alr_pkg::ST_WAIT;
        end
        alr_pkg::ST_ENDPT: begin
          out_valid <= 1'b1;
          out_last  <= major == alr_pkg::DIM_W'(2);
          state     <= alr_pkg::ST_WAIT;
        end
        alr_pkg::ST_STEP: begin
          state <= alr_pkg::ST_DIV;
        end
        alr_pkg::ST_DIV: begin
          if (div_done) state <= alr_pkg::ST_SHADE1;
        end
        alr_pkg::ST_SHADE1: begin
          state <= alr_pkg::ST_SHADE2;
        end
        alr_pkg::ST_SHADE2: begin
          state <= alr_pkg::ST_ADDR;
        end
        alr_pkg::ST_ADDR: begin
          out_valid <= 1'b1;
          out_last  <= {1'b0, step} == major - alr_pkg::DIM_W'(2);
          state     <= alr_pkg::ST_WAIT;
        end
        alr_pkg::ST_WAIT: begin
          if (m_axis_tready) begin
            out_valid <= 1'b0;
            if (out_last) state <= alr_pkg::ST_IDLE;
            else if (thin) state <= alr_pkg::ST_THIN;
            else state <= alr_pkg::ST_STEP;
          end
        end
        default: state <= alr_pkg::ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      alr_pkg::ST_IDLE: begin
        alpha <= s_axis_tdata[7:0];
        rgb   <= s_axis_tdata[31:8];
        dir   <= s_axis_tdata[32];
        w     <= w_in;
        h     <= h_in;
        thin  <= (w_in == alr_pkg::DIM_W'(1)) || (h_in == alr_pkg::DIM_W'(1));
        total <= w_in + h_in - alr_pkg::DIM_W'(1);
        steep <= h_in > w_in;
        major <= (h_in > w_in) ? h_in : w_in;
        span  <= (h_in > w_in) ? alr_pkg::POS_W'(w_in - alr_pkg::DIM_W'(1))
                               : alr_pkg::POS_W'(h_in - alr_pkg::DIM_W'(1));
        den   <= (h_in > w_in) ? alr_pkg::POS_W'(h_in - alr_pkg::DIM_W'(1))
                               : alr_pkg::POS_W'(w_in - alr_pkg::DIM_W'(1));
        p     <= '0;
        step  <= '0;
        pos   <= '0;
        rem   <= '0;
      end
      alr_pkg::ST_THIN: begin
        addr1 <= alr_pkg::ADDR_W'(p);
        val1  <= {alpha, rgb};
        ok2   <= ({1'b0, p} + 8'd1) < {1'b0, total};
        addr2 <= (({1'b0, p} + 8'd1) < {1'b0, total}) ? alr_pkg::ADDR_W'(p + alr_pkg::DIM_W'(1))
                                                       : '0;
        val2  <= (({1'b0, p} + 8'd1) < {1'b0, total}) ? {alpha, rgb} : 32'd0;
        p     <= alr_pkg::DIM_W'(p_next2);
      end
      alr_pkg::ST_ENDPT: begin
        addr1 <= dir ? '0 : alr_pkg::ADDR_W'(w - alr_pkg::DIM_W'(1));
        addr2 <= dir ? alr_pkg::ADDR_W'(prod - 17'd1) : alr_pkg::ADDR_W'(prod);
        val1  <= {alpha, rgb};
        val2  <= {alpha, rgb};
        ok2   <= 1'b1;
      end
      alr_pkg::ST_STEP: begin
        step <= step + alr_pkg::POS_W'(1);
        if (rem_sum >= {2'b00, den}) begin
          rem <= alr_pkg::POS_W'(rem_sum - {2'b00, den});
          pos <= pos + alr_pkg::POS_W'(1);
        end else begin
          rem <= alr_pkg::POS_W'(rem_sum);
        end
      end
      alr_pkg::ST_SHADE1: begin
        alpha1 <= prod[15:8];
      end
      alr_pkg::ST_SHADE2: begin
        val1 <= {alpha1, rgb};
        val2 <= {prod[15:8], rgb};
      end
      alr_pkg::ST_ADDR: begin
        addr1 <= a1_calc;
        addr2 <= steep ? a1_calc + alr_pkg::ADDR_W'(1) : a1_calc + {5'd0, w};
        ok2   <= 1'b1;
      end
      default: begin
        p <= p;
      end
    endcase
  end

endmodule

[tb/tb.sv]
// Self-checking testbench for the antialiased line rasterizer.
`timescale 1ns / 1ps

module tb;

  localparam int SETTLE_CYCLES = 24;
  localparam int HOLD_CYCLES   = 400;
  localparam int TAIL_CYCLES   = 40;

  typedef enum logic [2:0] {
    ACT_DRAW,
    ACT_WRITE_REG,
    ACT_DRAIN,
    ACT_HOLD_OUTPUT,
    ACT_CALM
  } plan_act_t;

  typedef struct {
    plan_act_t                     act;
    logic [alr_pkg::ALPHA_W-1:0]   alpha;
    logic [alr_pkg::RGB_W-1:0]     rgb;
    logic                          rising;
    logic                          reg_index;
    logic [alr_pkg::DIM_W-1:0]     reg_value;
  } plan_step_t;

  typedef struct {
    logic [alr_pkg::ADDR_W-1:0] addr_first;
    logic [31:0]                value_first;
    logic                       second_valid;
    logic [alr_pkg::ADDR_W-1:0] addr_second;
    logic [31:0]                value_second;
    logic                       last;
  } pixel_pair_t;

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        cfg_we = 1'b0;
  logic                        cfg_index = alr_pkg::REG_WIDTH;
  logic [alr_pkg::DIM_W-1:0]   cfg_data = '0;
  logic                        s_axis_tvalid = 1'b0;
  logic                        s_axis_tready;
  // color_alpha[7:0], color_rgb[31:8], rising_slope[32], zero[39:33]
  logic [alr_pkg::IN_W-1:0]    s_axis_tdata = '0;
  logic                        m_axis_tvalid;
  logic                        m_axis_tready = 1'b0;
  // addr_first[11:0], value_first[43:12], second_valid[44], addr_second[56:45],
  // value_second[88:57], zero[95:89]
  logic [alr_pkg::OUT_W-1:0]   m_axis_tdata;
  logic                        m_axis_tlast;

  plan_step_t                  request_plan[$];
  pixel_pair_t                 pending_pixel_writes[$];
  logic [alr_pkg::DIM_W-1:0]   width_reg = 7'd64;
  logic [alr_pkg::DIM_W-1:0]   height_reg = 7'd64;
  logic                        calm = 1'b0;
  logic                        hold_req = 1'b0;
  int                          hold_left = 0;
  int                          mismatch_count = 0;
  int                          draws_planned = 0;

  antialiased_line_raster u_top (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int clamp_dim(input logic [alr_pkg::DIM_W-1:0] v);
    if (v == 0) return 1;
    if (v > alr_pkg::MAX_DIM) return alr_pkg::MAX_DIM;
    return int'(v);
  endfunction

  function automatic logic [31:0] shade_word(input logic [alr_pkg::ALPHA_W-1:0] alpha,
                                             input logic [alr_pkg::RGB_W-1:0] rgb,
                                             input int weight);
    int prod;
    prod = int'(alpha) * weight;
    return {prod[15:8], rgb};
  endfunction

  function automatic void rasterize_line(input logic [alr_pkg::ALPHA_W-1:0] alpha,
                                         input logic [alr_pkg::RGB_W-1:0] rgb,
                                         input logic rising);
    int w, h, total, major, span, den, num, pos, rem, frac, line_idx, a1, a2;
    logic steep;
    logic [31:0] full;
    pixel_pair_t pp;
    w = clamp_dim(width_reg);
    h = clamp_dim(height_reg);
    full = {alpha, rgb};
    if (w == 1 || h == 1) begin
      total = w * h;
      for (int p = 0; p < total; p += 2) begin
        pp.addr_first = alr_pkg::ADDR_W'(p);
        pp.value_first = full;
        pp.second_valid = (p + 1 < total);
        pp.addr_second = pp.second_valid ? alr_pkg::ADDR_W'(p + 1) : '0;
        pp.value_second = pp.second_valid ? full : '0;
        pp.last = (p + 2 >= total);
        pending_pixel_writes.push_back(pp);
      end
    end else begin
      steep = h > w;
      major = steep ? h : w;
      span = steep ? w - 1 : h - 1;
      den = major - 1;
      pp.addr_first = rising ? '0 : alr_pkg::ADDR_W'(w - 1);
      pp.addr_second = rising ? alr_pkg::ADDR_W'(w * h - 1) : alr_pkg::ADDR_W'(w * (h - 1));
      pp.value_first = full;
      pp.value_second = full;
      pp.second_valid = 1'b1;
      pp.last = (major == 2);
      pending_pixel_writes.push_back(pp);
      for (int i = 1; i + 1 < major; i++) begin
        num = i * span;
        pos = num / den;
        rem = num % den;
        frac = (rem << alr_pkg::FRAC_BITS) / den;
        if (steep) begin
          line_idx = rising ? i : h - 1 - i;
          a1 = line_idx * w + pos;
          a2 = a1 + 1;
        end else begin
          line_idx = rising ? i : w - 1 - i;
          a1 = pos * w + line_idx;
          a2 = (pos + 1) * w + line_idx;
        end
        pp.addr_first = alr_pkg::ADDR_W'(a1);
        pp.value_first = shade_word(alpha, rgb, (1 << alr_pkg::FRAC_BITS) - frac);
        pp.second_valid = 1'b1;
        pp.addr_second = alr_pkg::ADDR_W'(a2);
        pp.value_second = shade_word(alpha, rgb, frac);
        pp.last = (i + 2 == major);
        pending_pixel_writes.push_back(pp);
      end
    end
  endfunction

  task automatic plan_draw(input logic [alr_pkg::ALPHA_W-1:0] alpha,
                           input logic [alr_pkg::RGB_W-1:0] rgb, input logic rising);
    plan_step_t s;
    s.act = ACT_DRAW;
    s.alpha = alpha;
    s.rgb = rgb;
    s.rising = rising;
    s.reg_index = alr_pkg::REG_WIDTH;
    s.reg_value = '0;
    request_plan.push_back(s);
    draws_planned++;
  endtask

  task automatic plan_marker(input plan_act_t act);
    plan_step_t s;
    s.act = act;
    s.alpha = '0;
    s.rgb = '0;
    s.rising = 1'b0;
    s.reg_index = alr_pkg::REG_WIDTH;
    s.reg_value = '0;
    request_plan.push_back(s);
  endtask

  task automatic plan_surface(input logic [alr_pkg::DIM_W-1:0] w,
                              input logic [alr_pkg::DIM_W-1:0] h);
    plan_step_t s;
    plan_marker(ACT_DRAIN);
    s.act = ACT_WRITE_REG;
    s.alpha = '0;
    s.rgb = '0;
    s.rising = 1'b0;
    s.reg_index = alr_pkg::REG_WIDTH;
    s.reg_value = w;
    request_plan.push_back(s);
    s.reg_index = alr_pkg::REG_HEIGHT;
    s.reg_value = h;
    request_plan.push_back(s);
  endtask

  task automatic plan_random_draw();
    logic [alr_pkg::ALPHA_W-1:0] alpha;
    case ($urandom_range(0, 5))
      0: alpha = 8'hff;
      1: alpha = 8'h00;
      default: alpha = alr_pkg::ALPHA_W'($urandom);
    endcase
    plan_draw(alpha, alr_pkg::RGB_W'($urandom), 1'($urandom));
  endtask

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  // request side
  always @(posedge clk) begin : drive_requests
    logic fire;
    logic nx_valid;
    logic [alr_pkg::IN_W-1:0] nx_data;
    logic nx_we;
    logic nx_index;
    logic [alr_pkg::DIM_W-1:0] nx_cfg;
    logic nx_hold;
    logic nx_calm;
    static int gap_left = 0;
    static int settle = 0;
    fire = s_axis_tvalid && s_axis_tready;
    nx_valid = s_axis_tvalid && !fire;
    nx_data = s_axis_tdata;
    nx_we = 1'b0;
    nx_index = cfg_index;
    nx_cfg = cfg_data;
    nx_hold = 1'b0;
    nx_calm = calm;
    if (rst) begin
      nx_valid = 1'b0;
      gap_left = 0;
      settle = 0;
    end else begin
      if (fire) begin
        rasterize_line(s_axis_tdata[7:0], s_axis_tdata[31:8], s_axis_tdata[32]);
        if (!calm && $urandom_range(0, 3) == 0) gap_left = $urandom_range(1, 17);
      end
      if (!nx_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (request_plan.size() > 0) begin
          case (request_plan[0].act)
            ACT_DRAW: begin
              nx_valid = 1'b1;
              nx_data = {7'd0, request_plan[0].rising, request_plan[0].rgb,
                         request_plan[0].alpha};
              void'(request_plan.pop_front());
            end
            ACT_WRITE_REG: begin
              nx_we = 1'b1;
              nx_index = request_plan[0].reg_index;
              nx_cfg = request_plan[0].reg_value;
              if (nx_index == alr_pkg::REG_WIDTH) width_reg = nx_cfg;
              else height_reg = nx_cfg;
              void'(request_plan.pop_front());
            end
            ACT_DRAIN: begin
              if (pending_pixel_writes.size() != 0) begin
                settle = 0;
              end else if (settle >= SETTLE_CYCLES) begin
                settle = 0;
                void'(request_plan.pop_front());
              end else begin
                settle++;
              end
            end
            ACT_HOLD_OUTPUT: begin
              nx_hold = 1'b1;
              void'(request_plan.pop_front());
            end
            default: begin
              nx_calm = 1'b1;
              void'(request_plan.pop_front());
            end
          endcase
        end
      end
    end
    s_axis_tvalid <= nx_valid;
    s_axis_tdata <= nx_data;
    cfg_we <= nx_we;
    cfg_index <= nx_index;
    cfg_data <= nx_cfg;
    hold_req <= nx_hold;
    calm <= nx_calm;
  end

  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (hold_req) begin
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // result side
  always @(posedge clk) begin : watch_results
    pixel_pair_t want;
    logic ready;
    static int stall_left = 0;
    if (rst) begin
      stall_left = 0;
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_pixel_writes.size() == 0) begin
          $display("%0t: unexpected result, expected none actual %h", $time, m_axis_tdata);
          mismatch_count++;
        end else begin
          want = pending_pixel_writes.pop_front();
          check_field("addr_first", 32'(want.addr_first), 32'(m_axis_tdata[11:0]));
          check_field("value_first", want.value_first, m_axis_tdata[43:12]);
          check_field("second_valid", 32'(want.second_valid), 32'(m_axis_tdata[44]));
          check_field("addr_second", 32'(want.addr_second), 32'(m_axis_tdata[56:45]));
          check_field("value_second", want.value_second, m_axis_tdata[88:57]);
          check_field("last_result", 32'(want.last), 32'(m_axis_tlast));
        end
      end
      if (hold_left != 0 || hold_req) begin
        ready = 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        ready = 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 16);
        ready = 1'b0;
      end else begin
        ready = 1'b1;
      end
      m_axis_tready <= ready;
    end
  end

  initial begin
    int mode;
    int runs;
    // corner draws on the reset surface
    plan_draw(8'hff, 24'hffffff, 1'b1);
    plan_draw(8'h00, 24'h000000, 1'b0);
    // thin surfaces: odd column, lone pixel, full row, full column
    plan_surface(7'd1, 7'd5);
    plan_draw(8'h80, 24'haaaaaa, 1'b1);
    plan_surface(7'd1, 7'd0);
    plan_draw(8'h7f, 24'h555555, 1'b0);
    plan_surface(7'd127, 7'd1);
    plan_draw(8'hff, 24'h123456, 1'b1);
    plan_surface(7'd0, 7'd64);
    plan_draw(8'h01, 24'hfedcba, 1'b0);
    // endpoints only
    plan_surface(7'd2, 7'd2);
    plan_draw(8'hc0, 24'h0000ff, 1'b1);
    plan_draw(8'h3f, 24'hff0000, 1'b0);
    // shallow line with a zero fraction step, then steep
    plan_surface(7'd5, 7'd3);
    plan_draw(8'hc3, 24'h0f0f0f, 1'b1);
    plan_draw(8'h3c, 24'hf0f0f0, 1'b0);
    plan_surface(7'd3, 7'd8);
    plan_draw(8'hff, 24'h00ff00, 1'b1);
    plan_draw(8'hab, 24'h5a5a5a, 1'b0);
    // long major axis with the result side held off
    plan_surface(7'd65, 7'd2);
    plan_marker(ACT_HOLD_OUTPUT);
    plan_draw(8'hff, 24'h13579b, 1'b0);
    plan_draw(8'h80, 24'h2468ac, 1'b1);
    plan_draw(8'h00, 24'hffffff, 1'b0);

    while (draws_planned < 340) begin
      mode = $urandom_range(0, 9);
      if (mode == 0) begin
        if ($urandom_range(0, 1) == 0) plan_surface(7'($urandom_range(0, 1)), 7'($urandom));
        else plan_surface(7'($urandom), 7'($urandom_range(0, 1)));
        runs = $urandom_range(3, 8);
      end else if (mode == 1) begin
        plan_surface(7'($urandom_range(40, 127)), 7'($urandom_range(40, 127)));
        runs = $urandom_range(1, 3);
      end else begin
        plan_surface(7'($urandom_range(2, 12)), 7'($urandom_range(2, 12)));
        runs = $urandom_range(6, 18);
      end
      repeat (runs) plan_random_draw();
    end
    plan_surface(7'($urandom_range(2, 10)), 7'($urandom_range(2, 10)));
    plan_marker(ACT_CALM);
    repeat (40) plan_random_draw();
    plan_marker(ACT_DRAIN);

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    do @(posedge clk); while (request_plan.size() != 0);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_pixel_writes.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
